[hdl/feature_track_builder_macros.svh]
// assertion macros for the feature track builder checker
`ifndef FEATURE_TRACK_BUILDER_MACROS_SVH
`define FEATURE_TRACK_BUILDER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define FTB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define FTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ftb_pkg.sv]
// shared types and constants of the feature track builder
package ftb_pkg;

    localparam int VIEW_W    = 5;
    localparam int FEAT_W    = 10;
    localparam int SLOT_W    = VIEW_W + FEAT_W;
    localparam int SLOTS     = 1 << SLOT_W;
    localparam int TRACK_W   = SLOT_W - 1;
    localparam int TRACKS    = 1 << TRACK_W;
    localparam int LABEL_W   = TRACK_W + 1;
    localparam int SIZE_W    = 16;
    localparam int OUTCOME_W = 3;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_NEW    = 3'd0,
        OC_JOIN_A = 3'd1,
        OC_JOIN_B = 3'd2,
        OC_SAME   = 3'd3,
        OC_MERGE  = 3'd4,
        OC_CLEAR  = 3'd5
    } t_outcome;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDB,
        S_DEC,
        S_NEW2,
        S_TRA,
        S_TRB,
        S_WALK,
        S_WWAIT,
        S_FIN,
        S_FIN2,
        S_OUT,
        S_CLR
    } t_state;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
        logic [SIZE_W-1:0] members;
    } t_track;

endpackage

[hdl/ftb_ram.sv]
// generic single-write, single-read synchronous ram with registered read
module ftb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/feature_track_builder.sv]
// feature track builder: union by size of feature correspondences into tracks
//
// Each input word is one correspondence (or a clear) and yields one result word.
// A match goes through these steps up to the next acceptance: accept, two
// reads of the label memory (it has one read port), a decision, and for joins or
// repeats one track-table read. A new track adds a second label write. A merge
// reads both track entries and walks the smaller track, with a label write for each
// relabeled feature and a member-chain read to reach the next. A result word waits
// in the output state while the previous one is still held by the receiver, and no
// input word is taken meanwhile. After reset and after every clear the label memory
// is swept, one entry a cycle, over all its entries, and no input word is taken
// meanwhile; the result of a clear is delivered when the sweep ends.
module feature_track_builder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [ftb_pkg::VIEW_W-1:0]    i_view_a,
    input  logic [ftb_pkg::FEAT_W-1:0]    i_feature_a,
    input  logic [ftb_pkg::VIEW_W-1:0]    i_view_b,
    input  logic [ftb_pkg::FEAT_W-1:0]    i_feature_b,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [ftb_pkg::OUTCOME_W-1:0] o_outcome,
    output logic [ftb_pkg::TRACK_W-1:0]   o_track_id,
    output logic [ftb_pkg::TRACK_W-1:0]   o_freed_track,
    output logic [ftb_pkg::SIZE_W-1:0]    o_track_size
);
    import ftb_pkg::*;

    t_state               r_state, n_state;
    logic [SLOT_W-1:0]    r_sa, r_sb, r_walk, r_sweep;
    logic [LABEL_W-1:0]   r_la, r_lb, r_used;
    logic [TRACK_W-1:0]   r_tid, r_keep, r_lose;
    t_track               r_ta, r_kt, r_lt;
    logic [SIZE_W-1:0]    r_cnt;
    logic                 r_clr_out;
    t_outcome             r_res_oc;
    logic [TRACK_W-1:0]   r_res_tid, r_res_freed;
    logic [SIZE_W-1:0]    r_res_size;
    logic                 r_ovalid;
    t_outcome             r_o_oc;
    logic [TRACK_W-1:0]   r_o_tid, r_o_freed;
    logic [SIZE_W-1:0]    r_o_size;

    logic                 lab_we;
    logic [SLOT_W-1:0]    lab_waddr, lab_raddr;
    logic [LABEL_W-1:0]   lab_wdata, lab_rdata;
    logic                 nxt_we;
    logic [SLOT_W-1:0]    nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;
    logic                 trk_we;
    logic [TRACK_W-1:0]   trk_waddr, trk_raddr;
    t_track               trk_wdata, trk_rdata;

    logic                 in_acc, out_free;
    logic [TRACK_W-1:0]   tid_sel, ta_id, tb_id;
    logic [SIZE_W-1:0]    sum;
    logic                 b_bigger;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_ovalid || !i_out_stall;
    assign tid_sel  = (r_la != '0) ? TRACK_W'(r_la - 1'b1) : TRACK_W'(lab_rdata - 1'b1);
    assign ta_id    = TRACK_W'(r_la - 1'b1);
    assign tb_id    = TRACK_W'(r_lb - 1'b1);
    assign sum      = r_kt.members + r_lt.members;
    assign b_bigger = r_ta.members < trk_rdata.members;

    ftb_ram #(.WIDTH(LABEL_W), .DEPTH(SLOTS)) u_label (
        .i_clk(i_clk), .i_we(lab_we), .i_waddr(lab_waddr), .i_wdata(lab_wdata),
        .i_raddr(lab_raddr), .o_rdata(lab_rdata)
    );

    ftb_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(nxt_raddr), .o_rdata(nxt_rdata)
    );

    ftb_ram #(.WIDTH($bits(t_track)), .DEPTH(TRACKS)) u_track (
        .i_clk(i_clk), .i_we(trk_we), .i_waddr(trk_waddr), .i_wdata(trk_wdata),
        .i_raddr(trk_raddr), .o_rdata(trk_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = i_kind ? S_CLR : S_RDB;
            S_RDB:   n_state = S_DEC;
            S_DEC: begin
                if (r_sa == r_sb) begin
                    n_state = (r_la == '0) ? S_OUT : S_TRA;
                end else if (r_la == '0 && lab_rdata == '0) begin
                    n_state = r_used[LABEL_W-1] ? S_OUT : S_NEW2;
                end else begin
                    n_state = S_TRA;
                end
            end
            S_NEW2:  n_state = S_OUT;
            S_TRA: begin
                if (r_la != '0 && r_lb != '0 && r_la != r_lb) n_state = S_TRB;
                else n_state = S_OUT;
            end
            S_TRB:   n_state = S_WALK;
            S_WALK:  n_state = (r_cnt == SIZE_W'(1)) ? S_FIN : S_WWAIT;
            S_WWAIT: n_state = S_WALK;
            S_FIN:   n_state = S_FIN2;
            S_FIN2:  n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            S_CLR: begin
                if (r_sweep == '1) n_state = r_clr_out ? S_OUT : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        lab_we    = 1'b0;
        lab_waddr = r_sa;
        lab_wdata = r_used;
        lab_raddr = r_sb;
        nxt_we    = 1'b0;
        nxt_waddr = r_sa;
        nxt_wdata = r_sb;
        nxt_raddr = r_walk;
        trk_we    = 1'b0;
        trk_waddr = r_tid;
        trk_wdata = '{head: r_sa, tail: r_sb, members: SIZE_W'(2)};
        trk_raddr = tid_sel;
        case (r_state)
            S_IDLE: lab_raddr = {i_view_a, i_feature_a};
            S_DEC: begin
                if (r_sa != r_sb && r_la == '0 && lab_rdata == '0 && !r_used[LABEL_W-1]) begin
                    lab_we    = 1'b1;
                    lab_wdata = r_used + 1'b1;
                    nxt_we    = 1'b1;
                    trk_we    = 1'b1;
                    trk_waddr = TRACK_W'(r_used);
                end
            end
            S_NEW2: begin
                lab_we    = 1'b1;
                lab_waddr = r_sb;
            end
            S_TRA: begin
                trk_raddr = tb_id;
                if (r_la == '0) begin
                    lab_we    = 1'b1;
                    lab_waddr = r_sa;
                    lab_wdata = r_lb;
                    nxt_we    = 1'b1;
                    nxt_waddr = trk_rdata.tail;
                    nxt_wdata = r_sa;
                    trk_we    = 1'b1;
                    trk_wdata = '{head: trk_rdata.head, tail: r_sa,
                                  members: trk_rdata.members + 1'b1};
                end else if (r_lb == '0) begin
                    lab_we    = 1'b1;
                    lab_waddr = r_sb;
                    lab_wdata = r_la;
                    nxt_we    = 1'b1;
                    nxt_waddr = trk_rdata.tail;
                    nxt_wdata = r_sb;
                    trk_we    = 1'b1;
                    trk_wdata = '{head: trk_rdata.head, tail: r_sb,
                                  members: trk_rdata.members + 1'b1};
                end
            end
            S_WALK: begin
                lab_we    = 1'b1;
                lab_waddr = r_walk;
                lab_wdata = {1'b0, r_keep} + 1'b1;
            end
            S_FIN: begin
                nxt_we    = 1'b1;
                nxt_waddr = r_kt.tail;
                nxt_wdata = r_lt.head;
                trk_we    = 1'b1;
                trk_waddr = r_keep;
                trk_wdata = '{head: r_kt.head, tail: r_lt.tail, members: sum};
            end
            S_FIN2: begin
                trk_we    = 1'b1;
                trk_waddr = r_lose;
                trk_wdata = '{head: r_lt.head, tail: r_lt.tail, members: '0};
            end
            S_CLR: begin
                lab_we    = 1'b1;
                lab_waddr = r_sweep;
                lab_wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_sweep   <= '0;
            r_clr_out <= 1'b0;
            r_used    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (!i_out_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sa <= {i_view_a, i_feature_a};
                        r_sb <= {i_view_b, i_feature_b};
                        if (i_kind) begin
                            r_sweep     <= '0;
                            r_clr_out   <= 1'b1;
                            r_used      <= '0;
                            r_res_oc    <= OC_CLEAR;
                            r_res_tid   <= '0;
                            r_res_freed <= '0;
                            r_res_size  <= '0;
                        end
                    end
                end
                S_RDB: r_la <= lab_rdata;
                S_DEC: begin
                    r_lb        <= lab_rdata;
                    r_tid       <= tid_sel;
                    r_res_freed <= '0;
                    if (r_sa != r_sb && r_la == '0 && lab_rdata == '0
                        && !r_used[LABEL_W-1]) begin
                        r_used     <= r_used + 1'b1;
                        r_res_oc   <= OC_NEW;
                        r_res_tid  <= TRACK_W'(r_used);
                        r_res_size <= SIZE_W'(2);
                    end else if (r_sa == r_sb || (r_la == '0 && lab_rdata == '0)) begin
                        r_res_oc   <= OC_SAME;
                        r_res_tid  <= '0;
                        r_res_size <= '0;
                    end
                end
                S_TRA: begin
                    r_ta      <= trk_rdata;
                    r_res_tid <= r_tid;
                    if (r_la == '0) begin
                        r_res_oc   <= OC_JOIN_A;
                        r_res_size <= trk_rdata.members + 1'b1;
                    end else if (r_lb == '0) begin
                        r_res_oc   <= OC_JOIN_B;
                        r_res_size <= trk_rdata.members + 1'b1;
                    end else begin
                        r_res_oc   <= OC_SAME;
                        r_res_size <= trk_rdata.members;
                    end
                end
                S_TRB: begin
                    if (b_bigger) begin
                        r_keep <= tb_id;
                        r_kt   <= trk_rdata;
                        r_lose <= ta_id;
                        r_lt   <= r_ta;
                        r_walk <= r_ta.head;
                        r_cnt  <= r_ta.members;
                    end else begin
                        r_keep <= ta_id;
                        r_kt   <= r_ta;
                        r_lose <= tb_id;
                        r_lt   <= trk_rdata;
                        r_walk <= trk_rdata.head;
                        r_cnt  <= trk_rdata.members;
                    end
                end
                S_WALK:  r_cnt <= r_cnt - 1'b1;
                S_WWAIT: r_walk <= nxt_rdata;
                S_FIN: begin
                    r_res_oc    <= OC_MERGE;
                    r_res_tid   <= r_keep;
                    r_res_freed <= r_lose;
                    r_res_size  <= sum;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_oc    <= r_res_oc;
                        r_o_tid   <= r_res_tid;
                        r_o_freed <= r_res_freed;
                        r_o_size  <= r_res_size;
                    end
                end
                S_CLR: r_sweep <= r_sweep + 1'b1;
                default: ;
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_outcome     = r_o_oc;
    assign o_track_id    = r_o_tid;
    assign o_freed_track = r_o_freed;
    assign o_track_size  = r_o_size;

endmodule

[hdl/ftb_checker.sv]
// port-level checker for the feature track builder, bound to the top level
`include "feature_track_builder_macros.svh"

module ftb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_kind,
    input logic [ftb_pkg::VIEW_W-1:0]    i_view_a,
    input logic [ftb_pkg::FEAT_W-1:0]    i_feature_a,
    input logic [ftb_pkg::VIEW_W-1:0]    i_view_b,
    input logic [ftb_pkg::FEAT_W-1:0]    i_feature_b,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [ftb_pkg::OUTCOME_W-1:0] o_outcome,
    input logic [ftb_pkg::TRACK_W-1:0]   o_track_id,
    input logic [ftb_pkg::TRACK_W-1:0]   o_freed_track,
    input logic [ftb_pkg::SIZE_W-1:0]    o_track_size
);
    import ftb_pkg::*;

    `FTB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_outcome) && $stable(o_track_size), "stalled word changed")
    `FTB_ASSERT_NOW(a_clear_zero, o_out_valid && o_outcome == OC_CLEAR,
        o_track_id == '0 && o_freed_track == '0 && o_track_size == '0, "clear not zero")
    `FTB_ASSERT_NOW(a_freed_merge, o_out_valid && o_outcome != OC_MERGE,
        o_freed_track == '0, "freed track outside merge")
    `FTB_ASSERT_NOW(a_new_two, o_out_valid && o_outcome == OC_NEW,
        o_track_size == 16'd2, "new track size not two")
    `FTB_ASSERT_NOW(a_merge_size, o_out_valid && o_outcome == OC_MERGE,
        o_track_size >= 16'd4 && o_track_id != o_freed_track, "bad merge result")

endmodule

bind feature_track_builder ftb_checker u_ftb_checker (.*);

[test/feature_track_checker.sv]
// checker for the feature track builder: predicts each result word and compares
module feature_track_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_kind,
    input  logic [ftb_pkg::VIEW_W-1:0]    i_view_a,
    input  logic [ftb_pkg::FEAT_W-1:0]    i_feature_a,
    input  logic [ftb_pkg::VIEW_W-1:0]    i_view_b,
    input  logic [ftb_pkg::FEAT_W-1:0]    i_feature_b,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [ftb_pkg::OUTCOME_W-1:0] i_outcome,
    input  logic [ftb_pkg::TRACK_W-1:0]   i_track_id,
    input  logic [ftb_pkg::TRACK_W-1:0]   i_freed_track,
    input  logic [ftb_pkg::SIZE_W-1:0]    i_track_size,
    output int                            o_errors,
    output int                            o_pending
);
    import ftb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUE_DEPTH = 16;

    typedef struct packed {
        t_outcome             outcome;
        logic [TRACK_W-1:0]   track_id;
        logic [TRACK_W-1:0]   freed;
        logic [SIZE_W-1:0]    size;
    } t_track_result;

    logic [LABEL_W-1:0] label_of [SLOTS];
    logic [SLOT_W-1:0]  chain_next [SLOTS];
    logic [SLOT_W-1:0]  head_of [TRACKS];
    logic [SLOT_W-1:0]  tail_of [TRACKS];
    logic [SIZE_W-1:0]  count_of [TRACKS];
    int unsigned        next_track;

    t_track_result      due_words [DUE_DEPTH];
    int unsigned        due_wr, due_rd;

    function automatic void wipe_tracks();
        for (int i = 0; i < SLOTS; i++) begin
            label_of[i] = '0;
            chain_next[i] = '0;
        end
        for (int i = 0; i < TRACKS; i++) begin
            head_of[i] = '0;
            tail_of[i] = '0;
            count_of[i] = '0;
        end
        next_track = 0;
    endfunction

    function automatic void add_member(int unsigned t, logic [SLOT_W-1:0] s);
        chain_next[tail_of[t]] = s;
        tail_of[t] = s;
        count_of[t] = count_of[t] + 1'b1;
        label_of[s] = LABEL_W'(t + 1);
    endfunction

    function automatic t_track_result link_features(logic kind, logic [SLOT_W-1:0] sa,
                                                    logic [SLOT_W-1:0] sb);
        t_track_result r;
        int unsigned la, lb, keep, lose, n;
        logic [SLOT_W-1:0] walk;
        r = '{OC_SAME, '0, '0, '0};
        if (kind) begin
            wipe_tracks();
            r.outcome = OC_CLEAR;
            return r;
        end
        la = label_of[sa];
        lb = label_of[sb];
        if (sa == sb) begin
            if (la != 0) begin
                r.track_id = TRACK_W'(la - 1);
                r.size = count_of[la - 1];
            end
        end else if (la == 0 && lb == 0) begin
            if (next_track < TRACKS) begin
                keep = next_track;
                next_track++;
                head_of[keep] = sa;
                tail_of[keep] = sa;
                count_of[keep] = SIZE_W'(1);
                label_of[sa] = LABEL_W'(keep + 1);
                add_member(keep, sb);
                r = '{OC_NEW, TRACK_W'(keep), '0, count_of[keep]};
            end
        end else if (la == 0) begin
            add_member(lb - 1, sa);
            r = '{OC_JOIN_A, TRACK_W'(lb - 1), '0, count_of[lb - 1]};
        end else if (lb == 0) begin
            add_member(la - 1, sb);
            r = '{OC_JOIN_B, TRACK_W'(la - 1), '0, count_of[la - 1]};
        end else if (la == lb) begin
            r = '{OC_SAME, TRACK_W'(la - 1), '0, count_of[la - 1]};
        end else begin
            keep = la - 1;
            lose = lb - 1;
            if (count_of[keep] < count_of[lose]) begin
                keep = lb - 1;
                lose = la - 1;
            end
            n = count_of[lose];
            walk = head_of[lose];
            for (int i = 0; i < n; i++) begin
                label_of[walk] = LABEL_W'(keep + 1);
                if (i + 1 < n) walk = chain_next[walk];
            end
            chain_next[tail_of[keep]] = head_of[lose];
            tail_of[keep] = tail_of[lose];
            count_of[keep] = count_of[keep] + SIZE_W'(n);
            count_of[lose] = '0;
            r = '{OC_MERGE, TRACK_W'(keep), TRACK_W'(lose), count_of[keep]};
        end
        return r;
    endfunction

    initial begin
        wipe_tracks();
        due_wr = 0;
        due_rd = 0;
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_track_result want;
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (due_wr == due_rd) begin
                o_errors++;
                if (o_errors <= 10)
                    $display("unexpected result word: outcome %0d track %0d",
                             i_outcome, i_track_id);
            end else begin
                want = due_words[due_rd % DUE_DEPTH];
                due_rd++;
                if (i_outcome !== want.outcome || i_track_id !== want.track_id ||
                    i_freed_track !== want.freed || i_track_size !== want.size) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                 want.outcome, want.track_id, want.freed, want.size,
                                 i_outcome, i_track_id, i_freed_track, i_track_size);
                end
            end
        end
        if (i_rst_n && i_in_valid && !i_in_stall) begin
            due_words[due_wr % DUE_DEPTH] = link_features(i_kind, {i_view_a, i_feature_a},
                                                          {i_view_b, i_feature_b});
            due_wr++;
        end
        o_pending = int'(due_wr - due_rd);
    end

endmodule

[test/tb_feature_track_builder.sv]
// testbench top for the feature track builder: stimulus, flow control and verdict
module tb_feature_track_builder;
    import ftb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;
    localparam int   RANDOM_WORDS = 1580;
    localparam int   POOL = 48;
    localparam longint CYCLE_LIMIT = 3000000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_kind = KIND_MATCH;
    logic [VIEW_W-1:0]    i_view_a = '0;
    logic [FEAT_W-1:0]    i_feature_a = '0;
    logic [VIEW_W-1:0]    i_view_b = '0;
    logic [FEAT_W-1:0]    i_feature_b = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [OUTCOME_W-1:0] o_outcome;
    logic [TRACK_W-1:0]   o_track_id;
    logic [TRACK_W-1:0]   o_freed_track;
    logic [SIZE_W-1:0]    o_track_size;

    int     errors, pending;
    bit     quiet = 1'b0;
    bit     squeeze = 1'b0;
    longint cycles = 0;
    logic [SLOT_W-1:0] pool [POOL];

    feature_track_builder u_top (.*);

    feature_track_checker u_check (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_kind,
        .i_view_a, .i_feature_a, .i_view_b, .i_feature_b,
        .i_out_valid(o_out_valid), .i_out_stall, .i_outcome(o_outcome),
        .i_track_id(o_track_id), .i_freed_track(o_freed_track),
        .i_track_size(o_track_size), .o_errors(errors), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_feature_track_builder: done, errors");
            $finish;
        end
    end

    // receiver flow control, with one long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (squeeze) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                squeeze = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(logic kind, logic [SLOT_W-1:0] sa, logic [SLOT_W-1:0] sb);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        {i_view_a, i_feature_a} <= sa;
        {i_view_b, i_feature_b} <= sb;
        do @(posedge i_clk); while (o_in_stall);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_match(logic [SLOT_W-1:0] sa, logic [SLOT_W-1:0] sb);
        send_word(KIND_MATCH, sa, sb);
    endtask

    initial begin
        logic [SLOT_W-1:0] sa, sb;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, every outcome, tie merge, self matches, clear
        send_match(15'h0000, 15'h0000);
        send_match(15'h0000, 15'h7fff);
        send_match(15'h7fff, 15'h7fff);
        send_match(15'h03ff, 15'h0000);
        send_match(15'h7fff, 15'h7c00);
        send_match(15'h0001, 15'h0002);
        send_match(15'h0003, 15'h0004);
        send_match(15'h0001, 15'h0004);
        send_match(15'h0005, 15'h0006);
        send_match(15'h0005, 15'h0003);
        send_match(15'h0002, 15'h0006);
        send_match(15'h0007, 15'h0008);
        send_match(15'h0009, 15'h0008);
        send_match(15'h0001, 15'h0009);
        send_match(15'h0007, 15'h0007);
        send_match(15'h4210, 15'h2108);
        send_word(KIND_CLEAR, 15'h7fff, 15'h7fff);
        send_match(15'h0000, 15'h7fff);
        send_match(15'h7fff, 15'h0001);

        for (int i = 0; i < POOL; i++) pool[i] = SLOT_W'($urandom);
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == 300) squeeze = 1'b1;
            if (i == RANDOM_WORDS - 200) quiet = 1'b1;
            sa = pool[$urandom_range(0, POOL - 1)];
            sb = pool[$urandom_range(0, POOL - 1)];
            if ($urandom_range(0, 9) == 0) sa = SLOT_W'($urandom);
            if ($urandom_range(0, 9) == 0) sb = SLOT_W'($urandom);
            if ($urandom_range(0, 399) == 0) begin
                send_word(KIND_CLEAR, SLOT_W'($urandom), SLOT_W'($urandom));
                for (int k = 0; k < POOL; k++) pool[k] = SLOT_W'($urandom);
            end else begin
                send_match(sa, sb);
            end
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0)
            $display("tb_feature_track_builder: done, clean");
        else
            $display("tb_feature_track_builder: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/ftb_pkg.sv
hdl/ftb_ram.sv
hdl/feature_track_builder.sv
hdl/ftb_checker.sv
test/feature_track_checker.sv
test/tb_feature_track_builder.sv
